// ===== rtl/core/zcrt_pkg.sv =====
package zcrt_pkg;

   localparam int SAMPLE_W = 32;
   localparam int TIME_W   = 48;
   localparam int GAP_W    = 16;
   localparam int LIMIT_W  = 8;
   localparam int DELAY_W  = 16;
   localparam int NUM_W    = SAMPLE_W + GAP_W;
   localparam int DEN_W    = SAMPLE_W + 1;
   localparam int DIV_CNT_W = $clog2(NUM_W);
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [GAP_W-1:0]   GAP_MIN_RESET    = 16'd333;
   localparam logic [GAP_W-1:0]   GAP_MAX_RESET    = 16'd555;
   localparam logic [LIMIT_W-1:0] SAMPLE_LIMIT_RESET = 8'd42;
   localparam logic [GAP_W-1:0]   NO_LOAD_RESET    = 16'd10;

   localparam logic [CSR_IDX_W-1:0] CSR_GAP_MIN      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_MAX      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_LIMIT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_LOAD      = 2'd3;

   localparam logic CMD_START  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef enum logic [2:0] {
      STATUS_IDLE     = 3'd0,
      STATUS_WAIT     = 3'd1,
      STATUS_FIRE     = 3'd2,
      STATUS_NO_LOAD  = 3'd3,
      STATUS_READ_ERR = 3'd4,
      STATUS_GAP_ERR  = 3'd5,
      STATUS_OFF_ERR  = 3'd6,
      STATUS_WATCHDOG = 3'd7
   } status_type;

   typedef struct packed {
      logic [GAP_W-1:0]   gap_min;
      logic [GAP_W-1:0]   gap_max;
      logic [LIMIT_W-1:0] sample_limit;
      logic [GAP_W-1:0]   no_load_level;
   } cfg_type;

   // One classified item: either a finished status or an interpolation to run
   typedef struct packed {
      logic                is_div;
      status_type          status;
      logic                level;
      logic [SAMPLE_W-1:0] v_mag;
      logic [GAP_W-1:0]    dt;
      logic [DEN_W-1:0]    den_mag;
      logic                quo_neg;
   } job_type;

endpackage

// ===== rtl/core/zcrt_front.sv =====
module zcrt_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic                            command,
   input  logic                            switch_on,
   input  logic [zcrt_pkg::SAMPLE_W-1:0]   sample_value,
   input  logic [zcrt_pkg::TIME_W-1:0]     time_us,
   input  logic                            read_error,
   input  zcrt_pkg::cfg_type               cfg,
   input  logic                            q_full,
   output logic                            q_push,
   output zcrt_pkg::job_type               q_job
);

   logic                            armed_ff, armed_in;
   logic                            level_ff, level_in;
   logic [zcrt_pkg::LIMIT_W-1:0]    count_ff, count_in;
   logic [zcrt_pkg::SAMPLE_W-1:0]   last_sample_ff, last_sample_in;
   logic [zcrt_pkg::TIME_W-1:0]     last_time_ff, last_time_in;

   logic                            accept;
   logic                            v_zero, cv_zero, v_pos;
   logic                            sign_change;
   logic [zcrt_pkg::TIME_W-1:0]     dt_full;
   logic                            gap_bad;
   logic [zcrt_pkg::DEN_W-1:0]      den;
   logic [zcrt_pkg::DEN_W-1:0]      den_mag;
   logic [zcrt_pkg::SAMPLE_W-1:0]   v_mag, cv_mag;
   logic [zcrt_pkg::LIMIT_W-1:0]    count_next;
   logic                            no_load_hit;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;
   assign q_push   = accept;

   always_comb begin
      v_zero  = (last_sample_ff == '0);
      cv_zero = (sample_value == '0);
      v_pos   = !last_sample_ff[zcrt_pkg::SAMPLE_W-1] && !v_zero;
      sign_change = (last_sample_ff[zcrt_pkg::SAMPLE_W-1] != sample_value[zcrt_pkg::SAMPLE_W-1])
                    || (v_zero != cv_zero);
      dt_full = time_us - last_time_ff;
      gap_bad = (dt_full > zcrt_pkg::TIME_W'(cfg.gap_max))
                || (dt_full < zcrt_pkg::TIME_W'(cfg.gap_min));
      den = {sample_value[zcrt_pkg::SAMPLE_W-1], sample_value}
            - {last_sample_ff[zcrt_pkg::SAMPLE_W-1], last_sample_ff};
      den_mag = den[zcrt_pkg::DEN_W-1] ? (~den + 1'b1) : den;
      v_mag   = last_sample_ff[zcrt_pkg::SAMPLE_W-1] ? (~last_sample_ff + 1'b1)
                                                      : last_sample_ff;
      cv_mag  = sample_value[zcrt_pkg::SAMPLE_W-1] ? (~sample_value + 1'b1) : sample_value;
      no_load_hit = (cv_mag <= zcrt_pkg::SAMPLE_W'(cfg.no_load_level));
      count_next  = count_ff + 1'b1;
   end

   always_comb begin
      armed_in       = armed_ff;
      level_in       = level_ff;
      count_in       = count_ff;
      last_sample_in = last_sample_ff;
      last_time_in   = last_time_ff;

      q_job.is_div  = 1'b0;
      q_job.status  = zcrt_pkg::STATUS_IDLE;
      q_job.level   = level_ff;
      q_job.v_mag   = v_mag;
      q_job.dt      = dt_full[zcrt_pkg::GAP_W-1:0];
      q_job.den_mag = den_mag;
      q_job.quo_neg = v_pos ^ den[zcrt_pkg::DEN_W-1];

      if (accept) begin
         if (command == zcrt_pkg::CMD_START) begin
            armed_in     = 1'b1;
            level_in     = switch_on;
            count_in     = '0;
            q_job.level  = switch_on;
            q_job.status = zcrt_pkg::STATUS_WAIT;
         end else if (!armed_ff) begin
            q_job.status = zcrt_pkg::STATUS_IDLE;
         end else if (read_error) begin
            armed_in     = 1'b0;
            q_job.status = zcrt_pkg::STATUS_READ_ERR;
         end else if ((count_ff > zcrt_pkg::LIMIT_W'(1)) && sign_change) begin
            // crossing: attempt ends here; unless the gap is out of window, interpolation runs in the back end
            armed_in = 1'b0;
            if (gap_bad) begin
               q_job.status = zcrt_pkg::STATUS_GAP_ERR;
            end else begin
               q_job.is_div = 1'b1;
               q_job.status = zcrt_pkg::STATUS_FIRE;
            end
         end else begin
            last_sample_in = sample_value;
            last_time_in   = time_us;
            count_in       = count_next;
            if (count_next >= cfg.sample_limit) begin
               armed_in = 1'b0;
               if (level_ff || !no_load_hit) begin
                  q_job.status = zcrt_pkg::STATUS_WATCHDOG;
               end else begin
                  q_job.status = zcrt_pkg::STATUS_NO_LOAD;
               end
            end else begin
               q_job.status = zcrt_pkg::STATUS_WAIT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff       <= 1'b0;
         level_ff       <= 1'b0;
         count_ff       <= '0;
         last_sample_ff <= '0;
         last_time_ff   <= '0;
      end else begin
         armed_ff       <= armed_in;
         level_ff       <= level_in;
         count_ff       <= count_in;
         last_sample_ff <= last_sample_in;
         last_time_ff   <= last_time_in;
      end
   end

endmodule

// ===== rtl/core/zcrt_queue.sv =====
module zcrt_queue #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  zcrt_pkg::job_type  push_data,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output zcrt_pkg::job_type  head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   zcrt_pkg::job_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/zcrt_back.sv =====
module zcrt_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  zcrt_pkg::job_type             q_job,
   output logic                          q_pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output zcrt_pkg::status_type          out_status,
   output logic [zcrt_pkg::DELAY_W-1:0]  out_delay,
   output logic                          out_level
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type                          state_ff, state_in;
   zcrt_pkg::job_type                  job_ff, job_in;
   logic [zcrt_pkg::NUM_W-1:0]         num_ff, num_in;
   logic [zcrt_pkg::DEN_W-1:0]         rem_ff, rem_in;
   logic [zcrt_pkg::NUM_W-1:0]         quo_ff, quo_in;
   logic [zcrt_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;

   logic                               out_valid_ff, out_valid_in;
   zcrt_pkg::status_type               out_status_ff, out_status_in;
   logic [zcrt_pkg::DELAY_W-1:0]       out_delay_ff, out_delay_in;
   logic                               out_level_ff, out_level_in;

   logic                               out_free;
   logic [zcrt_pkg::DEN_W:0]           trial;
   logic [zcrt_pkg::DEN_W:0]           trial_diff;
   logic                               off_bad;

   assign out_valid  = out_valid_ff;
   assign out_status = out_status_ff;
   assign out_delay  = out_delay_ff;
   assign out_level  = out_level_ff;
   assign out_free   = !out_valid_ff || out_ready;

   always_comb begin
      trial      = {rem_ff, num_ff[zcrt_pkg::NUM_W-1]};
      trial_diff = trial - {1'b0, job_ff.den_mag};
      // truncated quotient must land in [0, dt]
      off_bad    = job_ff.quo_neg ? (quo_ff != '0)
                                  : (quo_ff > zcrt_pkg::NUM_W'(job_ff.dt));
   end

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      q_pop         = 1'b0;
      out_valid_in  = out_valid_ff && !out_ready;
      out_status_in = out_status_ff;
      out_delay_in  = out_delay_ff;
      out_level_in  = out_level_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_job.is_div) begin
                  q_pop    = 1'b1;
                  job_in   = q_job;
                  state_in = ST_MUL;
               end else if (out_free) begin
                  q_pop         = 1'b1;
                  out_valid_in  = 1'b1;
                  out_status_in = q_job.status;
                  out_delay_in  = '0;
                  out_level_in  = q_job.level;
               end
            end
         end
         ST_MUL: begin
            num_in   = {{zcrt_pkg::GAP_W{1'b0}}, job_ff.v_mag}
                       * {{zcrt_pkg::SAMPLE_W{1'b0}}, job_ff.dt};
            rem_in   = '0;
            quo_in   = '0;
            cnt_in   = zcrt_pkg::DIV_CNT_W'(zcrt_pkg::NUM_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // one restoring step per cycle, dividend MSB first
            num_in = {num_ff[zcrt_pkg::NUM_W-2:0], 1'b0};
            if (!trial_diff[zcrt_pkg::DEN_W]) begin
               rem_in = trial_diff[zcrt_pkg::DEN_W-1:0];
               quo_in = {quo_ff[zcrt_pkg::NUM_W-2:0], 1'b1};
            end else begin
               rem_in = trial[zcrt_pkg::DEN_W-1:0];
               quo_in = {quo_ff[zcrt_pkg::NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_level_in = job_ff.level;
               if (off_bad) begin
                  out_status_in = zcrt_pkg::STATUS_OFF_ERR;
                  out_delay_in  = '0;
               end else begin
                  out_status_in = zcrt_pkg::STATUS_FIRE;
                  out_delay_in  = quo_ff[zcrt_pkg::DELAY_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      out_status_ff <= out_status_in;
      out_delay_ff  <= out_delay_in;
      out_level_ff  <= out_level_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== rtl/core/zero_cross_relay_timing_top.sv =====
// Channel  Direction  Content
// req_*    in         start command or timestamped sample
// rsp_*    out        one status result per request
// csr_*    in         register writes (gap window, sample limit, no-load level)
//
// A request that needs no interpolation goes through the job queue to the result register.
// A crossing runs through the back end: pop in ST_IDLE, multiply in ST_MUL, the
// one-bit-per-cycle restoring divider in ST_DIV and the result in ST_DONE; no new job is popped until then.
// The front end keeps taking requests while the job queue (QUEUE_DEPTH) has room.
// Reset is synchronous: attempt disarmed, queue emptied, registers to defaults.
// A stalled rsp_tready holds the result register and backs up through the queue.
module zero_cross_relay_timing_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [0] switch_on, [32:1] sample_value, [80:33] time_us, [87:81] zero
   input  logic [87:0]                          req_tdata,
   // [0] command, [1] read_error
   input  logic [1:0]                           req_tuser,

   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [15:0] delay_us, [16] relay_level, [23:17] zero
   output logic [23:0]                          rsp_tdata,
   // [2:0] status
   output logic [2:0]                           rsp_tuser,

   input  logic                                 csr_wr_en,
   input  logic [zcrt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [zcrt_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   zcrt_pkg::cfg_type                  cfg_ff, cfg_in;
   logic                               q_push, q_full, q_pop, q_valid;
   zcrt_pkg::job_type                  q_wr_job, q_head;
   zcrt_pkg::status_type               out_status;
   logic [zcrt_pkg::DELAY_W-1:0]       out_delay;
   logic                               out_level;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            zcrt_pkg::CSR_GAP_MIN:      cfg_in.gap_min = csr_wr_data;
            zcrt_pkg::CSR_GAP_MAX:      cfg_in.gap_max = csr_wr_data;
            zcrt_pkg::CSR_SAMPLE_LIMIT:
               cfg_in.sample_limit = csr_wr_data[zcrt_pkg::LIMIT_W-1:0];
            zcrt_pkg::CSR_NO_LOAD:      cfg_in.no_load_level = csr_wr_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gap_min       <= zcrt_pkg::GAP_MIN_RESET;
         cfg_ff.gap_max       <= zcrt_pkg::GAP_MAX_RESET;
         cfg_ff.sample_limit  <= zcrt_pkg::SAMPLE_LIMIT_RESET;
         cfg_ff.no_load_level <= zcrt_pkg::NO_LOAD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   zcrt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .command      (req_tuser[0]),
      .switch_on    (req_tdata[0]),
      .sample_value (req_tdata[32:1]),
      .time_us      (req_tdata[80:33]),
      .read_error   (req_tuser[1]),
      .cfg          (cfg_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_job        (q_wr_job)
   );

   zcrt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_job),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head      (q_head)
   );

   zcrt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_job      (q_head),
      .q_pop      (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_status (out_status),
      .out_delay  (out_delay),
      .out_level  (out_level)
   );

   assign rsp_tdata = {7'b0, out_level, out_delay};
   assign rsp_tuser = out_status;

   // front end never pushes into a full queue
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("job pushed into full queue");

   // delay is only carried by a fire result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != zcrt_pkg::STATUS_FIRE)) |-> (rsp_tdata[15:0] == '0))
      else $error("nonzero delay on non-fire result");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

// ===== tb/sv/zero_cross_relay_timing_top_tb.sv =====
`timescale 1ns / 100ps

module zero_cross_relay_timing_top_tb;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int SETTLE_TICKS = 80;

   localparam int RDY_ALWAYS = 0;
   localparam int RDY_COIN   = 1;
   localparam int RDY_SPARSE = 2;
   localparam int RDY_RUNS   = 3;

   typedef struct packed {
      logic               cmd;
      logic               on;
      logic signed [31:0] value;
      logic [47:0]        stamp;
      logic               rd_err;
   } relay_req_type;

   typedef struct packed {
      zcrt_pkg::status_type status;
      logic [15:0]          delay;
      logic                 level;
   } relay_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   logic                            csr_wr_en   = 1'b0;
   logic [zcrt_pkg::CSR_IDX_W-1:0]  csr_index   = '0;
   logic [zcrt_pkg::CSR_DATA_W-1:0] csr_wr_data = '0;

   // Register copies used by the timing predictor
   logic [15:0] gap_min_cfg = 16'd333;
   logic [15:0] gap_max_cfg = 16'd555;
   logic [7:0]  limit_cfg   = 8'd42;
   logic [15:0] no_load_cfg = 16'd10;

   // Attempt state of the timing predictor
   logic               armed_m       = 1'b0;
   logic               level_m       = 1'b0;
   logic [7:0]         count_m       = '0;
   logic signed [31:0] last_sample_m = '0;
   logic [47:0]        last_time_m   = '0;

   relay_req_type    pending_req_q[$];
   relay_result_type expected_status_q[$];

   relay_req_type cur_req;
   int burst_left = 0;
   int gap_left   = 0;
   int stall_left = 0;
   int stall_mode = RDY_ALWAYS;

   int reqs_queued    = 0;
   int reqs_sent      = 0;
   int results_seen   = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   int status_hits[8];

   zero_cross_relay_timing_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic relay_result_type predict_relay(relay_req_type r);
      relay_result_type res;
      longint prev, cur, num, den, off, mag;
      logic [47:0] dt;
      res.status = zcrt_pkg::STATUS_WAIT;
      res.delay  = '0;
      if (r.cmd == zcrt_pkg::CMD_START) begin
         armed_m = 1'b1;
         level_m = r.on;
         count_m = '0;
      end else if (!armed_m) begin
         res.status = zcrt_pkg::STATUS_IDLE;
      end else if (r.rd_err) begin
         armed_m    = 1'b0;
         res.status = zcrt_pkg::STATUS_READ_ERR;
      end else begin
         prev = $signed(last_sample_m);
         cur  = $signed(r.value);
         dt   = r.stamp - last_time_m;
         if (count_m > 8'd1 && ((prev > 0) != (cur > 0) || (prev < 0) != (cur < 0))) begin
            armed_m = 1'b0;
            if (dt > gap_max_cfg || dt < gap_min_cfg) begin
               res.status = zcrt_pkg::STATUS_GAP_ERR;
            end else begin
               num = -prev * longint'(dt);
               den = cur - prev;
               off = num / den;
               if (off < 0 || off > longint'(dt)) begin
                  res.status = zcrt_pkg::STATUS_OFF_ERR;
               end else begin
                  res.status = zcrt_pkg::STATUS_FIRE;
                  res.delay  = off[15:0];
               end
            end
         end else begin
            last_sample_m = r.value;
            last_time_m   = r.stamp;
            count_m       = count_m + 8'd1;
            if (count_m >= limit_cfg) begin
               armed_m = 1'b0;
               mag = (cur < 0) ? -cur : cur;
               if (level_m || mag > longint'(no_load_cfg))
                  res.status = zcrt_pkg::STATUS_WATCHDOG;
               else
                  res.status = zcrt_pkg::STATUS_NO_LOAD;
            end
         end
      end
      res.level = level_m;
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH @%0t result %0d: %s", $time, results_seen, what);
   endtask

   // Driver: bursts of transfers separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_status_q.push_back(predict_relay(cur_req));
            reqs_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_req_q.size() > 0) begin
               cur_req = pending_req_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {7'd0, cur_req.stamp, cur_req.value, cur_req.on};
               req_tuser  <= {cur_req.rd_err, cur_req.cmd};
               if (burst_left > 0)
                  burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  case ($urandom_range(0, 4))
                     0, 1:    gap_left = 0;
                     2:       gap_left = $urandom_range(10, 40);
                     default: gap_left = $urandom_range(1, 4);
                  endcase
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: ready pattern switches between modes in segments
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(RDY_ALWAYS, RDY_RUNS);
         stall_left = $urandom_range(8, 160);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         RDY_ALWAYS: rsp_tready <= 1'b1;
         RDY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         RDY_SPARSE: rsp_tready <= ($urandom_range(0, 4) == 0);
         default:    rsp_tready <= stall_left[3];
      endcase
   end

   // Monitor: check each result transfer against the oldest expectation
   always @(posedge clock) begin
      relay_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_status_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result status=%0d", rsp_tuser));
         end else begin
            exp_res = expected_status_q.pop_front();
            status_hits[exp_res.status]++;
            if (rsp_tuser !== exp_res.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_tuser, exp_res.status));
            if (rsp_tdata[15:0] !== exp_res.delay)
               report_mismatch($sformatf("delay_us %0d, want %0d",
                                         rsp_tdata[15:0], exp_res.delay));
            if (rsp_tdata[16] !== exp_res.level)
               report_mismatch($sformatf("relay_level %0b, want %0b",
                                         rsp_tdata[16], exp_res.level));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_status_q.size());
         $display("Verification failed");
         $finish;
      end
   end

   task automatic write_csr(input logic [zcrt_pkg::CSR_IDX_W-1:0] idx,
                            input logic [15:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         zcrt_pkg::CSR_GAP_MIN:      gap_min_cfg = val;
         zcrt_pkg::CSR_GAP_MAX:      gap_max_cfg = val;
         zcrt_pkg::CSR_SAMPLE_LIMIT: limit_cfg   = val[7:0];
         zcrt_pkg::CSR_NO_LOAD:      no_load_cfg = val;
         default: ;
      endcase
   endtask

   task automatic set_config(input int gmin, input int gmax, input int lim, input int nl);
      write_csr(zcrt_pkg::CSR_GAP_MIN, 16'(gmin));
      write_csr(zcrt_pkg::CSR_GAP_MAX, 16'(gmax));
      write_csr(zcrt_pkg::CSR_SAMPLE_LIMIT, 16'(lim));
      write_csr(zcrt_pkg::CSR_NO_LOAD, 16'(nl));
   endtask

   task automatic add_req(input logic cmd, input logic on, input logic [31:0] value,
                          input logic [47:0] stamp, input logic rd_err);
      relay_req_type r;
      r.cmd    = cmd;
      r.on     = on;
      r.value  = value;
      r.stamp  = stamp;
      r.rd_err = rd_err;
      pending_req_q.push_back(r);
      reqs_queued++;
   endtask

   // Hold until everything queued has gone out and every result is back
   task automatic drain_all();
      do @(posedge clock);
      while (pending_req_q.size() != 0 || req_tvalid || expected_status_q.size() != 0);
   endtask

   function automatic logic [47:0] rand_stamp();
      logic [63:0] r64;
      r64 = {$urandom, $urandom};
      // land near the wrap point now and then
      if ($urandom_range(0, 3) == 0)
         r64[47:16] = '1;
      return r64[47:0];
   endfunction

   function automatic int pick_gap();
      int lo, hi;
      lo = gap_min_cfg;
      hi = gap_max_cfg;
      if (lo <= hi && $urandom_range(0, 9) < 8)
         return $urandom_range(lo, hi);
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, lo);
         1:       return hi + $urandom_range(1, 300);
         2:       return $urandom_range(0, 1) ? lo : hi;
         default: return $urandom_range(0, 70000);
      endcase
   endfunction

   function automatic logic [31:0] pick_value(input logic neg, input logic near_floor);
      logic [31:0] mag;
      int sel;
      sel = $urandom_range(0, 9);
      if (near_floor)
         mag = $urandom_range(0, int'(no_load_cfg) + 3);
      else if (sel == 0)
         mag = '0;
      else if (sel == 1)
         mag = 32'h7FFF_FFFF;
      else if (sel < 5)
         mag = $urandom & 32'h7FFF_FFFF;
      else
         mag = $urandom_range(1, 4095);
      if (neg && sel == 1 && !near_floor)
         return 32'h8000_0000;
      return neg ? -mag : mag;
   endfunction

   // One switching attempt: start, then a sample train that usually crosses zero
   task automatic queue_attempt();
      logic level, neg, flat, near_floor;
      logic [47:0] stamp;
      int kind, n_before, n_total, err_at, i;
      level = $urandom_range(0, 1);
      kind  = $urandom_range(0, 9);
      flat  = (kind < 2);
      add_req(zcrt_pkg::CMD_START, level, $urandom, rand_stamp(), $urandom_range(0, 1));
      stamp = rand_stamp();
      neg   = $urandom_range(0, 1);
      near_floor = flat && !level && $urandom_range(0, 2) != 0;
      if (flat) begin
         n_total  = (limit_cfg > 40) ? 40 : ((limit_cfg == 0) ? 1 : limit_cfg);
         n_before = n_total;
      end else begin
         n_before = $urandom_range(1, 8);
         n_total  = n_before + 1;
      end
      err_at = (kind == 2) ? $urandom_range(0, n_total - 1) : -1;
      for (i = 0; i < n_total; i++) begin
         stamp = stamp + pick_gap();
         if (i == n_before)
            neg = !neg;
         add_req(zcrt_pkg::CMD_SAMPLE, $urandom_range(0, 1), pick_value(neg, near_floor),
                 stamp, i == err_at);
      end
   endtask

   task automatic run_phase(input int gmin, input int gmax, input int lim, input int nl,
                            input int n_items);
      int base, i, n_noise;
      set_config(gmin, gmax, lim, nl);
      base = reqs_queued;
      while (reqs_queued - base < n_items) begin
         if ($urandom_range(0, 99) < 85) begin
            queue_attempt();
         end else begin
            n_noise = $urandom_range(1, 4);
            for (i = 0; i < n_noise; i++)
               add_req(($urandom_range(0, 3) != 0) ? zcrt_pkg::CMD_SAMPLE
                                                   : zcrt_pkg::CMD_START,
                       $urandom_range(0, 1), $urandom, rand_stamp(),
                       $urandom_range(0, 3) == 0);
         end
      end
      drain_all();
   endtask

   initial begin
      logic [47:0] t;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset values: idle sample, extreme crossing across the time wrap,
      // read error, zero-sign crossings at both ends of the delay range
      t = 48'hFFFF_FFFF_FF00;
      add_req(zcrt_pkg::CMD_SAMPLE, 1'b1, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
      add_req(zcrt_pkg::CMD_START, 1'b1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
      add_req(zcrt_pkg::CMD_SAMPLE, 1'b1, 32'h7FFF_FFFF, t, 1'b0);
      t = t + 48'd333;
      add_req(zcrt_pkg::CMD_SAMPLE, 1'b0, 32'h7FFF_FFFF, t, 1'b0);
      t = t + 48'd333;
      add_req(zcrt_pkg::CMD_SAMPLE, 1'b1, 32'h8000_0000, t, 1'b0);
      add_req(zcrt_pkg::CMD_START, 1'b0, 32'h0, 48'h0, 1'b0);
      add_req(zcrt_pkg::CMD_SAMPLE, 1'b1, -32'sd5, 48'd1000, 1'b0);
      add_req(zcrt_pkg::CMD_SAMPLE, 1'b0, 32'd77, 48'd1400, 1'b1);
      add_req(zcrt_pkg::CMD_START, 1'b1, 32'h0, 48'h0, 1'b0);
      add_req(zcrt_pkg::CMD_SAMPLE, 1'b0, 32'd0, 48'd2000, 1'b0);
      add_req(zcrt_pkg::CMD_SAMPLE, 1'b0, 32'd0, 48'd2400, 1'b0);
      add_req(zcrt_pkg::CMD_SAMPLE, 1'b0, 32'd0, 48'd2800, 1'b0);
      add_req(zcrt_pkg::CMD_SAMPLE, 1'b0, 32'd7, 48'd3200, 1'b0);
      add_req(zcrt_pkg::CMD_START, 1'b0, 32'h0, 48'h0, 1'b0);
      add_req(zcrt_pkg::CMD_SAMPLE, 1'b1, -32'sd100, 48'd5000, 1'b0);
      add_req(zcrt_pkg::CMD_SAMPLE, 1'b1, -32'sd50, 48'd5555, 1'b0);
      add_req(zcrt_pkg::CMD_SAMPLE, 1'b1, 32'd0, 48'd6110, 1'b0);
      drain_all();

      // Short limit: no-load off at the threshold, then watchdog just above it
      set_config(333, 555, 3, 10);
      add_req(zcrt_pkg::CMD_START, 1'b0, 32'h0, 48'h0, 1'b0);
      add_req(zcrt_pkg::CMD_SAMPLE, 1'b0, 32'd50, 48'd100, 1'b0);
      add_req(zcrt_pkg::CMD_SAMPLE, 1'b0, 32'd20, 48'd500, 1'b0);
      add_req(zcrt_pkg::CMD_SAMPLE, 1'b0, 32'd10, 48'd900, 1'b0);
      add_req(zcrt_pkg::CMD_START, 1'b0, 32'h0, 48'h0, 1'b0);
      add_req(zcrt_pkg::CMD_SAMPLE, 1'b0, -32'sd3, 48'd100, 1'b0);
      add_req(zcrt_pkg::CMD_SAMPLE, 1'b0, -32'sd5, 48'd500, 1'b0);
      add_req(zcrt_pkg::CMD_SAMPLE, 1'b0, -32'sd11, 48'd900, 1'b0);
      drain_all();

      run_phase(333, 555, 42, 10, 220);
      run_phase(0, 65535, 255, 65535, 200);
      run_phase(65535, 0, 3, 0, 180);
      run_phase(100, 400, 5, 2000, 200);
      run_phase(500, 500, 0, 300, 80);
      run_phase(333, 555, 1, 10, 60);
      begin
         int gmin;
         gmin = $urandom_range(0, 600);
         run_phase(gmin, gmin + $urandom_range(0, 600), $urandom_range(3, 20),
                   $urandom_range(0, 5000), 240);
      end

      repeat (SETTLE_TICKS) @(posedge clock);
      $display("Covered %0d requests over 9 register settings, %0d results checked",
               reqs_sent, results_seen);
      $display("Fire %0d, no-load %0d, read err %0d, gap err %0d, watchdog %0d, idle %0d",
               status_hits[zcrt_pkg::STATUS_FIRE], status_hits[zcrt_pkg::STATUS_NO_LOAD],
               status_hits[zcrt_pkg::STATUS_READ_ERR], status_hits[zcrt_pkg::STATUS_GAP_ERR],
               status_hits[zcrt_pkg::STATUS_WATCHDOG], status_hits[zcrt_pkg::STATUS_IDLE]);
      if (mismatch_count == 0 && expected_status_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
